### design/thb_pkg.sv
// Shared types and constants for the threshold-binned histogram unit.
// Holds command codes, payload structs and the controller/datapath interface.
// No dependencies.
package thb_pkg;

  localparam int unsigned MaxBinsDefault    = 64;
  localparam int unsigned CountWidthDefault = 32;
  localparam int unsigned ValueWidth        = 64;
  localparam int unsigned IndexWidth        = 6;
  localparam int unsigned OutCountWidth     = 32;
  localparam int unsigned BinsRegWidth      = 7;
  localparam int unsigned PaddrWidth        = 3;
  localparam int unsigned PdataWidth        = 32;

  // register indexes on the configuration port
  localparam logic [0:0] RegBinsInUse = 1'b0;

  typedef enum logic [1:0] {
    CMD_PIXEL,
    CMD_LOAD,
    CMD_READ,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic [ValueWidth-1:0]   value;
    logic [IndexWidth-1:0]   bin_index;
  } req_t;

  typedef struct packed {
    logic                     binned;
    logic [IndexWidth-1:0]    hit_bin;
    logic [OutCountWidth-1:0] bin_count;
    logic                     load_error;
  } res_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_ZERO,
    EMIT_PIXEL,
    EMIT_LOAD,
    EMIT_READ
  } emit_e;

  // controller to datapath
  typedef struct packed {
    logic  capture;
    logic  ptr_inc;
    logic  bin_take;
    logic  bin_prev;
    logic  clr_counts;
    emit_e emit;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic n_zero;
    logic first;
    logic last;
    logic le;
  } stat_t;

endpackage

### design/thb_ctrl.sv
// Controller state machine of the threshold-binned histogram unit.
// Sequences the threshold scan, counter update, load, read and clear.
// Depends on thb_pkg.
module thb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  thb_pkg::cmd_e   cmd_i,
  input  thb_pkg::stat_t  stat_i,
  output thb_pkg::ctrl_t  ctrl_o,
  output logic            busy_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COUNT,
    S_LOAD,
    S_READ,
    S_CLEAR
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    ctrl_o  = '0;
    ctrl_o.emit = thb_pkg::EMIT_NONE;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.capture = 1'b1;
          case (cmd_i)
            thb_pkg::CMD_PIXEL: state_d = S_SCAN;
            thb_pkg::CMD_LOAD:  state_d = S_LOAD;
            thb_pkg::CMD_READ:  state_d = S_READ;
            thb_pkg::CMD_CLEAR: state_d = S_CLEAR;
            default:            state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        // at or below the lowest threshold, or empty table: not counted
        if (stat_i.n_zero || (stat_i.first && stat_i.le)) begin
          ctrl_o.emit = thb_pkg::EMIT_ZERO;
          state_d     = S_IDLE;
        end else if (stat_i.le) begin
          ctrl_o.bin_take = 1'b1;
          ctrl_o.bin_prev = 1'b1;
          state_d         = S_COUNT;
        end else if (stat_i.last) begin
          ctrl_o.bin_take = 1'b1;
          state_d         = S_COUNT;
        end else begin
          ctrl_o.ptr_inc = 1'b1;
        end
      end
      S_COUNT: begin
        ctrl_o.emit = thb_pkg::EMIT_PIXEL;
        state_d     = S_IDLE;
      end
      S_LOAD: begin
        ctrl_o.emit = thb_pkg::EMIT_LOAD;
        state_d     = S_IDLE;
      end
      S_READ: begin
        ctrl_o.emit = thb_pkg::EMIT_READ;
        state_d     = S_IDLE;
      end
      S_CLEAR: begin
        ctrl_o.emit       = thb_pkg::EMIT_ZERO;
        ctrl_o.clr_counts = 1'b1;
        state_d           = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

### design/thb_dp.sv
// Datapath of the threshold-binned histogram unit.
// Threshold memory, counter memory with valid bits, compare, saturating
// increment and the result register. Depends on thb_pkg.
module thb_dp #(
  parameter int unsigned MAX_BINS    = thb_pkg::MaxBinsDefault,
  parameter int unsigned COUNT_WIDTH = thb_pkg::CountWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  thb_pkg::req_t                      req_i,
  input  logic [thb_pkg::BinsRegWidth-1:0]   bins_in_use_i,
  input  thb_pkg::ctrl_t                     ctrl_i,
  output thb_pkg::stat_t                     stat_o,
  output thb_pkg::res_t                      res_o,
  output logic                               res_valid_o
);

  localparam int unsigned AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned NW = $clog2(MAX_BINS + 1);

  logic [thb_pkg::ValueWidth-1:0] thr_mem [MAX_BINS];
  logic [COUNT_WIDTH-1:0]         cnt_mem [MAX_BINS];
  logic [MAX_BINS-1:0]            cnt_vld_q;

  logic [thb_pkg::ValueWidth-1:0] value_q;
  logic [thb_pkg::IndexWidth-1:0] idx_q;
  logic                           in_range_q;
  logic [NW-1:0]                  n_q, n_d;
  logic [AW-1:0]                  ptr_q, ptr_d;
  logic [AW-1:0]                  bin_q, bin_d;
  logic [AW-1:0]                  idx_addr, thr_raddr;
  logic [thb_pkg::ValueWidth-1:0] thr_rd_q;
  logic [COUNT_WIDTH-1:0]         cnt_rd_q;
  logic [COUNT_WIDTH-1:0]         cnt_cur, cnt_inc;
  logic                           le;
  thb_pkg::res_t                  res_q, res_d;
  logic                           res_valid_q;

  assign idx_addr = AW'(req_i.bin_index);
  assign n_d = (32'(bins_in_use_i) > MAX_BINS) ? NW'(MAX_BINS) : NW'(bins_in_use_i);

  always_comb begin
    if (ctrl_i.capture) begin
      ptr_d = '0;
    end else if (ctrl_i.ptr_inc) begin
      ptr_d = ptr_q + AW'(1);
    end else begin
      ptr_d = ptr_q;
    end
  end

  // a load compares against the entry below its index
  assign thr_raddr = (ctrl_i.capture && req_i.cmd == thb_pkg::CMD_LOAD)
                   ? AW'(req_i.bin_index - 6'd1) : ptr_d;

  always_comb begin
    if (ctrl_i.capture) begin
      bin_d = idx_addr;
    end else if (ctrl_i.bin_prev) begin
      bin_d = ptr_q - AW'(1);
    end else begin
      bin_d = ptr_q;
    end
  end

  assign le = (value_q <= thr_rd_q);

  assign stat_o.n_zero = (n_q == '0);
  assign stat_o.first  = (ptr_q == '0);
  assign stat_o.last   = (NW'(ptr_q) == n_q - NW'(1));
  assign stat_o.le     = le;

  // a counter never written since the last clear reads as zero
  assign cnt_cur = cnt_vld_q[bin_q] ? cnt_rd_q : '0;
  assign cnt_inc = (&cnt_cur) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);

  always_comb begin
    res_d = '0;
    case (ctrl_i.emit)
      thb_pkg::EMIT_PIXEL: begin
        res_d.binned    = 1'b1;
        res_d.hit_bin   = 6'(bin_q);
        res_d.bin_count = 32'(cnt_inc);
      end
      thb_pkg::EMIT_LOAD: begin
        res_d.hit_bin    = idx_q;
        res_d.load_error = !in_range_q || ((idx_q != '0) && le);
      end
      thb_pkg::EMIT_READ: begin
        res_d.hit_bin   = idx_q;
        res_d.bin_count = (in_range_q && cnt_vld_q[bin_q]) ? 32'(cnt_rd_q) : '0;
      end
      default: res_d = '0;
    endcase
  end

  // item payload and pointers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      value_q    <= req_i.value;
      idx_q      <= req_i.bin_index;
      in_range_q <= (32'(req_i.bin_index) < MAX_BINS);
      n_q        <= n_d;
    end
    if (ctrl_i.capture || ctrl_i.bin_take) begin
      bin_q <= bin_d;
    end
    ptr_q <= ptr_d;
    if (ctrl_i.emit != thb_pkg::EMIT_NONE) begin
      res_q <= res_d;
    end
  end

  // threshold memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit == thb_pkg::EMIT_LOAD && in_range_q) begin
      thr_mem[AW'(idx_q)] <= value_q;
    end
    thr_rd_q <= thr_mem[thr_raddr];
  end

  // counter memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit == thb_pkg::EMIT_PIXEL) begin
      cnt_mem[bin_q] <= cnt_inc;
    end
    cnt_rd_q <= cnt_mem[bin_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.clr_counts) begin
        cnt_vld_q <= '0;
      end else if (ctrl_i.emit == thb_pkg::EMIT_PIXEL) begin
        cnt_vld_q[bin_q] <= 1'b1;
      end
      res_valid_q <= (ctrl_i.emit != thb_pkg::EMIT_NONE);
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

### design/threshold_bin_histogram_unit.sv
// Top level of the threshold-binned histogram unit: APB register, controller
// and datapath. Depends on thb_pkg, thb_ctrl and thb_dp.
//
//   channel   signals                          transfer when
//   --------  -------------------------------  ----------------------------------
//   command   start, busy, req_i               start high and busy low
//   result    result_valid_o, result_o         result_valid_o high, one cycle
//   config    psel..pready (APB)               psel, penable, pwrite, pready high
//
// A counted pixel is compared against k thresholds, from the lowest upward, and
// then passes through the count state, where k is 1 to bins_in_use, capped at
// MAX_BINS; the single-port threshold memory yields one compare per cycle.
// An uncounted pixel stops at its first compare; other commands use one state.
// The result strobe comes in the cycle after the last working cycle, with busy
// already low. Reset clears all counters and bins_in_use; thresholds hold
// whatever was last written. Results cannot be stalled.
module threshold_bin_histogram_unit #(
  parameter int unsigned MAX_BINS    = thb_pkg::MaxBinsDefault,
  parameter int unsigned COUNT_WIDTH = thb_pkg::CountWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  thb_pkg::req_t                    req_i,
  output logic                             result_valid_o,
  output thb_pkg::res_t                    result_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [thb_pkg::PaddrWidth-1:0]   paddr,
  input  logic [thb_pkg::PdataWidth-1:0]   pwdata,
  output logic [thb_pkg::PdataWidth-1:0]   prdata,
  output logic                             pready
);

  logic [thb_pkg::BinsRegWidth-1:0] bins_q;
  logic                             reg_sel;
  thb_pkg::ctrl_t                   ctrl;
  thb_pkg::stat_t                   stat;

  assign reg_sel = (paddr[thb_pkg::PaddrWidth-1:2] == thb_pkg::RegBinsInUse);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? thb_pkg::PdataWidth'(bins_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      bins_q <= pwdata[thb_pkg::BinsRegWidth-1:0];
    end
  end

  thb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (req_i.cmd),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  thb_dp #(
    .MAX_BINS    (MAX_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .bins_in_use_i (bins_q),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .res_o         (result_o),
    .res_valid_o   (result_valid_o)
  );

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_hit_bin_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.binned) |-> (7'(result_o.hit_bin) < bins_q))
    else $error("counted pixel landed outside the active bins");

endmodule

### tb/threshold_bin_histogram_unit_tb.sv
// Self-checking testbench for threshold_bin_histogram_unit: drives pixel, load, read and clear
// commands, programs bins_in_use over APB, and checks each result against an internal histogram.
// Depends on thb_pkg and the unit's RTL.
`timescale 1ns / 1ps

module threshold_bin_histogram_unit_tb;

  localparam int unsigned NumBins    = thb_pkg::MaxBinsDefault;
  localparam int unsigned ItemTarget = 1250;
  localparam int unsigned CycleLimit = 1_000_000;

  logic                           clk_i   = 1'b0;
  logic                           rst_ni  = 1'b0;
  logic                           start   = 1'b0;
  logic                           busy;
  thb_pkg::req_t                  req_i   = '0;
  logic                           result_valid_o;
  thb_pkg::res_t                  result_o;
  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [thb_pkg::PaddrWidth-1:0] paddr   = '0;
  logic [thb_pkg::PdataWidth-1:0] pwdata  = '0;
  logic [thb_pkg::PdataWidth-1:0] prdata;
  logic                           pready;

  threshold_bin_histogram_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk_i = ~clk_i;

  // histogram as the unit should hold it
  logic [63:0] thr_table [NumBins];
  logic [31:0] bin_tally [NumBins];
  logic [6:0]  active_bins = '0;

  // what the generator knows about the table it has already queued loads for
  logic        thr_loaded [NumBins];
  logic [63:0] thr_shadow [NumBins];

  thb_pkg::req_t cmd_backlog[$];
  thb_pkg::res_t bin_results_due[$];

  int unsigned   queued = 0;
  int unsigned   errors = 0;
  int unsigned   cycles = 0;
  int unsigned   gap_left = 0;
  logic          no_gaps = 1'b0;
  int unsigned   settings_used = 0;
  int unsigned   n_binned = 0, n_missed = 0, n_loads = 0, n_flagged = 0;
  int unsigned   n_reads = 0, n_clears = 0;
  thb_pkg::res_t want;
  thb_pkg::res_t pred_res;

  initial begin
    for (int i = 0; i < NumBins; i++) begin
      thr_table[i]  = '0;
      bin_tally[i]  = '0;
      thr_loaded[i] = 1'b0;
      thr_shadow[i] = '0;
    end
  end

  function automatic thb_pkg::res_t histogram_update(thb_pkg::req_t r);
    thb_pkg::res_t o;
    int unsigned   n;
    int unsigned   b;
    logic          found;
    o = '0;
    n = (active_bins > NumBins) ? NumBins : active_bins;
    case (r.cmd)
      thb_pkg::CMD_PIXEL: begin
        if (n != 0 && r.value > thr_table[0]) begin
          b = n - 1;
          found = 1'b0;
          // first threshold at or above the pixel closes the bin below it
          for (int i = 1; i < n; i++) begin
            if (!found && r.value <= thr_table[i]) begin
              b = i - 1;
              found = 1'b1;
            end
          end
          if (bin_tally[b] != '1) bin_tally[b]++;
          o.binned    = 1'b1;
          o.hit_bin   = b[thb_pkg::IndexWidth-1:0];
          o.bin_count = bin_tally[b];
          n_binned++;
        end else begin
          n_missed++;
        end
      end
      thb_pkg::CMD_LOAD: begin
        o.hit_bin = r.bin_index;
        if (r.bin_index != 0 && r.value <= thr_table[r.bin_index - 1]) o.load_error = 1'b1;
        thr_table[r.bin_index] = r.value;
        n_loads++;
        if (o.load_error) n_flagged++;
      end
      thb_pkg::CMD_READ: begin
        o.hit_bin   = r.bin_index;
        o.bin_count = bin_tally[r.bin_index];
        n_reads++;
      end
      default: begin
        for (int i = 0; i < NumBins; i++) bin_tally[i] = '0;
        n_clears++;
      end
    endcase
    return o;
  endfunction

  // command driver: hold each command until transfer, insert random idle bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      req_i    <= '0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        pred_res = histogram_update(req_i);
        bin_results_due = {bin_results_due, pred_res};
      end
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_backlog.size() != 0 && !no_gaps && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 8);
          start    <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          req_i <= cmd_backlog.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (bin_results_due.size() == 0) begin
        $error("result with nothing pending: %p", result_o);
        errors++;
      end else begin
        want = bin_results_due.pop_front();
        check_field("binned", 64'(want.binned), 64'(result_o.binned));
        check_field("hit_bin", 64'(want.hit_bin), 64'(result_o.hit_bin));
        check_field("bin_count", 64'(want.bin_count), 64'(result_o.bin_count));
        check_field("load_error", 64'(want.load_error), 64'(result_o.load_error));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void add_cmd(thb_pkg::cmd_e c, logic [63:0] v,
                                  logic [thb_pkg::IndexWidth-1:0] idx);
    thb_pkg::req_t r;
    r.cmd       = c;
    r.value     = v;
    r.bin_index = idx;
    cmd_backlog = {cmd_backlog, r};
    queued++;
    if (c == thb_pkg::CMD_LOAD) begin
      thr_loaded[idx] = 1'b1;
      thr_shadow[idx] = v;
    end
  endfunction

  function automatic int loaded_prefix();
    int p;
    p = 0;
    while (p < NumBins && thr_loaded[p]) p++;
    return p;
  endfunction

  function automatic void build_table(int m, logic [63:0] mask, logic ascending);
    logic [63:0] step_max;
    logic [63:0] v;
    step_max = mask / (m + 1);
    if (step_max == 0) step_max = 1;
    v = rand64() % (step_max + 1);
    for (int i = 0; i < m; i++) begin
      add_cmd(thb_pkg::CMD_LOAD, ascending ? v : (rand64() & mask),
              i[thb_pkg::IndexWidth-1:0]);
      v = v + 1 + (rand64() % step_max);
    end
  endfunction

  function automatic logic [63:0] pick_pixel(int m, logic [63:0] mask);
    int unsigned k;
    k = (m > 0) ? $urandom_range(0, m - 1) : 0;
    case ($urandom_range(0, 19))
      0:          return '0;
      1:          return '1;
      2, 3:       return rand64();
      4, 5, 6, 7: return (m > 0) ? thr_shadow[k] : rand64();
      8, 9, 10:   return (m > 0) ? thr_shadow[k] + 1 : rand64();
      default:    return rand64() & mask;
    endcase
  endfunction

  function automatic logic [63:0] pick_load(int idx, logic [63:0] mask);
    if (idx == 0) return rand64() & mask;
    case ($urandom_range(0, 3))
      0:       return thr_shadow[idx - 1];
      1:       return rand64() & mask;
      default: return thr_shadow[idx - 1] + 1 + ($urandom & 32'hF);
    endcase
  endfunction

  task automatic write_bins_in_use(input logic [6:0] n);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {thb_pkg::RegBinsInUse, 2'b00};
    // upper data bits are don't-care for a 7-bit register
    pwdata  <= {(($urandom_range(0, 3) == 0) ? 25'($urandom) : 25'd0), n};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    active_bins = n;
    settings_used++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // read back the register through prdata
    @(posedge clk_i);
    check_field("prdata", 64'(n), 64'(prdata));
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (cmd_backlog.size() != 0 || start || bin_results_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int          n;
    int          m;
    int          len;
    int          p;
    int          idx;
    int          w;
    logic [63:0] mask;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table: nothing is counted, loads still land
    add_cmd(thb_pkg::CMD_PIXEL, '1, '0);
    add_cmd(thb_pkg::CMD_READ, '0, 6'd0);
    add_cmd(thb_pkg::CMD_READ, '0, 6'd63);
    add_cmd(thb_pkg::CMD_LOAD, 64'd0, 6'd0);
    add_cmd(thb_pkg::CMD_LOAD, 64'd100, 6'd1);
    add_cmd(thb_pkg::CMD_LOAD, 64'd100, 6'd2);
    add_cmd(thb_pkg::CMD_LOAD, 64'd200, 6'd2);
    add_cmd(thb_pkg::CMD_LOAD, '1, 6'd3);
    add_cmd(thb_pkg::CMD_LOAD, 64'd5, 6'd4);
    add_cmd(thb_pkg::CMD_CLEAR, '0, '0);
    add_cmd(thb_pkg::CMD_PIXEL, 64'd5, '0);
    wait_idle();

    // three bins, boundaries on both sides of each threshold
    write_bins_in_use(7'd3);
    add_cmd(thb_pkg::CMD_PIXEL, 64'd0, '0);
    add_cmd(thb_pkg::CMD_PIXEL, 64'd1, '0);
    add_cmd(thb_pkg::CMD_PIXEL, 64'd100, '0);
    add_cmd(thb_pkg::CMD_PIXEL, 64'd101, '0);
    add_cmd(thb_pkg::CMD_PIXEL, 64'd200, '0);
    add_cmd(thb_pkg::CMD_PIXEL, 64'd201, '0);
    add_cmd(thb_pkg::CMD_PIXEL, '1, '0);
    add_cmd(thb_pkg::CMD_READ, '0, 6'd2);
    add_cmd(thb_pkg::CMD_READ, '0, 6'd63);
    add_cmd(thb_pkg::CMD_CLEAR, '0, '0);
    add_cmd(thb_pkg::CMD_READ, '0, 6'd1);
    add_cmd(thb_pkg::CMD_PIXEL, 64'd150, '0);
    wait_idle();

    // five bins over a table that is out of order at the top
    write_bins_in_use(7'd5);
    add_cmd(thb_pkg::CMD_PIXEL, 64'h8000_0000_0000_0000, '0);
    add_cmd(thb_pkg::CMD_PIXEL, 64'd6, '0);
    wait_idle();

    while (queued < ItemTarget) begin
      case ($urandom_range(0, 15))
        0:       n = 0;
        1:       n = 1;
        2:       n = 64;
        3:       n = 127;
        4:       n = $urandom_range(65, 126);
        5, 6:    n = $urandom_range(21, 63);
        default: n = $urandom_range(2, 20);
      endcase
      m = (n > NumBins) ? NumBins : n;
      case ($urandom_range(0, 3))
        0:       w = 8;
        1:       w = 16;
        2:       w = 32;
        default: w = 64;
      endcase
      mask = (w == 64) ? '1 : ((64'd1 << w) - 1);
      no_gaps = (queued + 150 > ItemTarget);
      write_bins_in_use(7'(n));
      if (m > 0 && (loaded_prefix() < m || $urandom_range(0, 2) == 0))
        build_table(m, mask, $urandom_range(0, 4) != 0);
      len = $urandom_range(15, 60);
      for (int j = 0; j < len; j++) begin
        case ($urandom_range(0, 19))
          0, 1: add_cmd(thb_pkg::CMD_READ, rand64(), 6'($urandom_range(0, 63)));
          2:    add_cmd(thb_pkg::CMD_CLEAR, rand64(), 6'($urandom_range(0, 63)));
          3, 4: begin
            // only load where the entry below has been written
            p   = loaded_prefix();
            idx = $urandom_range(0, (p > NumBins - 1) ? NumBins - 1 : p);
            add_cmd(thb_pkg::CMD_LOAD, pick_load(idx, mask), idx[thb_pkg::IndexWidth-1:0]);
          end
          default: add_cmd(thb_pkg::CMD_PIXEL, pick_pixel(m, mask),
                           6'($urandom_range(0, 63)));
        endcase
      end
      wait_idle();
    end

    repeat (80) @(posedge clk_i);
    $display("Ran %0d commands across %0d bins_in_use settings (0 to 127)", queued,
             settings_used);
    $display("pixels binned %0d, not binned %0d; loads %0d (%0d flagged); reads %0d; clears %0d",
             n_binned, n_missed, n_loads, n_flagged, n_reads, n_clears);
    if (errors == 0 && bin_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
